// File: sv/yyxo_pkg.sv
// package for the yin-yang xy oscillator: beat types, sequencer codes, sine table
`default_nettype none

package yyxo_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int ADDR_W      = 9;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] BODY_SCALE   = 32'h5555_5556;
    localparam logic [63:0] PI_Q62       = 64'hC90F_DAA2_2168_C235;

    typedef struct packed {
        logic [11:0] main_knob;
        logic [11:0] x_knob;
        logic [11:0] y_knob;
    } in_item_t;

    typedef struct packed {
        logic signed [11:0] left_sample;
        logic signed [11:0] right_sample;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OSC,
        S_PHA,
        S_PB,
        S_SA,
        S_SB,
        S_SC,
        S_XY,
        S_L1,
        S_L2,
        S_R1,
        S_R2
    } state_t;

    typedef enum logic [1:0] {
        SHAPE_EYE,
        SHAPE_TOP,
        SHAPE_BOT,
        SHAPE_MID
    } shape_t;

    typedef logic signed [15:0] sine_word_t;
    typedef sine_word_t [TABLE_DEPTH-1:0] sine_table_t;

    function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[127:64];
    endfunction

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // trunc(32000 * sin(k*pi/256)) from an odd power series in q62
    function automatic sine_word_t quarter_value(input logic [7:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        if (k == 8'd0)
            return 16'sd0;
        if (k >= 8'd128)
            return 16'sd32000;
        x    = mul_hi(PI_Q62, {k, 56'd0});
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        term = mul_q62(term, x2) / 64'd6;   sum = sum - term;
        term = mul_q62(term, x2) / 64'd20;  sum = sum + term;
        term = mul_q62(term, x2) / 64'd42;  sum = sum - term;
        term = mul_q62(term, x2) / 64'd72;  sum = sum + term;
        term = mul_q62(term, x2) / 64'd110; sum = sum - term;
        term = mul_q62(term, x2) / 64'd156; sum = sum + term;
        term = mul_q62(term, x2) / 64'd210; sum = sum - term;
        term = mul_q62(term, x2) / 64'd272; sum = sum + term;
        term = mul_q62(term, x2) / 64'd342; sum = sum - term;
        term = mul_q62(term, x2) / 64'd420; sum = sum + term;
        term = mul_q62(term, x2) / 64'd506; sum = sum - term;
        term = mul_q62(term, x2) / 64'd600; sum = sum + term;
        r = mul_hi(sum, 64'd128000);
        return r[15:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        logic [8:0]  idx;
        logic [7:0]  q;
        logic [8:0]  mirror;
        sine_word_t  v;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            idx    = 9'(i);
            q      = idx[7:0];
            mirror = 9'd256 - {1'b0, q};
            v      = (q <= 8'd128) ? quarter_value(q) : quarter_value(mirror[7:0]);
            t[i]   = idx[8] ? -v : v;
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

// File: sv/yinyang_xy_oscillator.sv
// yin-yang xy oscillator: one shared multiplier under a sequencer, one sine rom
// steps per beat: oscillator update, phase product, body split (skipped for the eye arc),
// four interpolated sine lookups through S_SA, S_SB and S_SC, point forming, then the rotation
// products; S_R2 holds until the output register is free. No new beat is taken until the
// sequencer is back in idle. The pace is set by the single 33x33 multiplier and one-port rom.
// reset: rst_n asynchronous active low clears both phases, the sequencer and out_valid
`default_nettype none

module yinyang_xy_oscillator
    import yyxo_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    // sequencer and phase state
    state_t state_reg, state_next;
    shape_t shape_reg, shape_next;
    logic [31:0] osc_phase_reg, osc_phase_next;
    logic [31:0] rot_phase_reg, rot_phase_next;
    logic [1:0]  sine_cnt_reg, sine_cnt_next;

    // working registers
    in_item_t    knob_reg, knob_next;
    logic [31:0] ph_reg, ph_next;
    logic [31:0] base_reg, base_next;
    logic [ADDR_W-1:0] sine_idx_reg, sine_idx_next;
    logic [15:0] frac_reg, frac_next;
    logic signed [39:0] acc_reg, acc_next;
    logic signed [15:0] sv_reg [4];
    logic signed [15:0] sv_next [4];
    logic signed [17:0] x_reg, x_next;
    logic signed [17:0] y_reg, y_next;
    logic signed [11:0] left_reg, left_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    // shared multiplier and rom port
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;
    logic signed [39:0] acc_sum;
    logic signed [39:0] acc_dif;
    logic [ADDR_W-1:0]  rom_addr;
    logic signed [15:0] rom_q_reg;

    logic [31:0] sine_phase;
    logic [31:0] rot_step;
    logic [31:0] ph_all;
    logic [31:0] pb;
    logic [16:0] frac_inv;
    logic signed [17:0] s0;
    logic signed [17:0] s1;
    logic signed [17:0] px;
    logic signed [17:0] py;

    function automatic logic signed [11:0] sat12(input logic signed [39:0] v);
        logic signed [27:0] w;
        w = 28'(v >>> 12);
        if (w > 28'sd2047)
            return 12'sd2047;
        else if (w < -28'sd2048)
            return -12'sd2048;
        else
            return w[11:0];
    endfunction

    assign prod    = mul_a * mul_b;
    assign acc_sum = acc_reg + prod[39:0];
    assign acc_dif = acc_reg - prod[39:0];

    // phase of the current lookup: shape pair first, then sine and cosine of rotation
    assign sine_phase = (sine_cnt_reg[1] ? rot_phase_reg : base_reg)
                      + (sine_cnt_reg[0] ? QUARTER_TURN : 32'd0);
    assign rot_step   = ({20'd0, knob_reg.y_knob} - 32'd2048) << 10;
    assign ph_all     = prod[43:12];
    assign pb         = prod[61:30];
    assign frac_inv   = 17'd65536 - {1'b0, frac_reg};

    // arc point from the two shape lookups
    always_comb
    begin
        s0 = 18'(sv_reg[0]);
        s1 = 18'(sv_reg[1]);
        unique case (shape_reg)
            SHAPE_EYE:
            begin
                px = s0 >>> 2;
                py = 18'sd1024 - (s1 >>> 2);
            end
            SHAPE_TOP:
            begin
                px = s0 >>> 1;
                py = 18'sd1024 - (s1 >>> 1);
            end
            SHAPE_BOT:
            begin
                px = s0 >>> 1;
                py = (s1 >>> 1) - 18'sd1024;
            end
            SHAPE_MID:
            begin
                px = -s0;
                py = s1;
            end
            default:
            begin
                px = s0;
                py = s1;
            end
        endcase
    end

    // sine rom, registered read
    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_TABLE[rom_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            shape_reg     <= SHAPE_EYE;
            osc_phase_reg <= 32'd0;
            rot_phase_reg <= 32'd0;
            sine_cnt_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shape_reg     <= shape_next;
            osc_phase_reg <= osc_phase_next;
            rot_phase_reg <= rot_phase_next;
            sine_cnt_reg  <= sine_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        knob_reg     <= knob_next;
        ph_reg       <= ph_next;
        base_reg     <= base_next;
        sine_idx_reg <= sine_idx_next;
        frac_reg     <= frac_next;
        acc_reg      <= acc_next;
        sv_reg       <= sv_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        left_reg     <= left_next;
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        shape_next     = shape_reg;
        osc_phase_next = osc_phase_reg;
        rot_phase_next = rot_phase_reg;
        sine_cnt_next  = sine_cnt_reg;
        knob_next      = knob_reg;
        ph_next        = ph_reg;
        base_next      = base_reg;
        sine_idx_next  = sine_idx_reg;
        frac_next      = frac_reg;
        acc_next       = acc_reg;
        sv_next        = sv_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        mul_a          = '0;
        mul_b          = '0;
        rom_addr       = sine_idx_reg;

        in_ready  = (state_reg == S_IDLE);
        out_valid = out_valid_reg;
        out_item  = out_item_reg;

        // result beat taken downstream
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    knob_next  = in_item;
                    state_next = S_OSC;
                end
            end
            S_OSC:
            begin
                // main knob squared, times eight
                mul_a          = {21'd0, knob_reg.main_knob};
                mul_b          = {21'd0, knob_reg.main_knob};
                osc_phase_next = osc_phase_reg + {5'd0, prod[23:0], 3'd0};
                rot_phase_next = rot_phase_reg + rot_step;
                state_next     = S_PHA;
            end
            S_PHA:
            begin
                // doubled phase scaled by x knob << 20, high word kept
                mul_a         = {1'b0, osc_phase_reg[30:0], 1'b0};
                mul_b         = {21'd0, knob_reg.x_knob};
                ph_next       = ph_all;
                sine_cnt_next = 2'd0;
                if (ph_all[31:30] == 2'b11)
                begin
                    shape_next = SHAPE_EYE;
                    base_next  = {ph_all[28:0], 3'd0};
                    state_next = S_SA;
                end
                else
                begin
                    state_next = S_PB;
                end
            end
            S_PB:
            begin
                // body phase spread over three arcs
                mul_a = {1'b0, ph_reg};
                mul_b = {1'b0, BODY_SCALE};
                unique case (pb[31:30])
                    2'b00:
                    begin
                        shape_next = SHAPE_TOP;
                        base_next  = {pb[30:0], 1'b0};
                    end
                    2'b11:
                    begin
                        shape_next = SHAPE_BOT;
                        base_next  = {pb[30:0], 1'b0};
                    end
                    default:
                    begin
                        shape_next = SHAPE_MID;
                        base_next  = pb - QUARTER_TURN;
                    end
                endcase
                state_next = S_SA;
            end
            S_SA:
            begin
                // fetch the lower table point
                rom_addr      = sine_phase[31:23];
                sine_idx_next = sine_phase[31:23];
                frac_next     = sine_phase[22:7];
                state_next    = S_SB;
            end
            S_SB:
            begin
                // fetch the upper point, weight the lower one
                rom_addr   = sine_idx_reg + 9'd1;
                mul_a      = 33'(rom_q_reg);
                mul_b      = {16'd0, frac_inv};
                acc_next   = prod[39:0];
                state_next = S_SC;
            end
            S_SC:
            begin
                mul_a                 = 33'(rom_q_reg);
                mul_b                 = {17'd0, frac_reg};
                sv_next[sine_cnt_reg] = acc_sum[35:20];
                if (sine_cnt_reg == 2'd3)
                begin
                    sine_cnt_next = 2'd0;
                    state_next    = S_XY;
                end
                else
                begin
                    sine_cnt_next = sine_cnt_reg + 2'd1;
                    state_next    = S_SA;
                end
            end
            S_XY:
            begin
                // second half cycle flips the point
                x_next     = osc_phase_reg[31] ? -px : px;
                y_next     = osc_phase_reg[31] ? -py : py;
                state_next = S_L1;
            end
            S_L1:
            begin
                mul_a      = 33'(x_reg);
                mul_b      = 33'(sv_reg[2]);
                acc_next   = prod[39:0];
                state_next = S_L2;
            end
            S_L2:
            begin
                mul_a      = 33'(y_reg);
                mul_b      = 33'(sv_reg[3]);
                left_next  = sat12(acc_sum);
                state_next = S_R1;
            end
            S_R1:
            begin
                mul_a      = 33'(x_reg);
                mul_b      = 33'(sv_reg[3]);
                acc_next   = prod[39:0];
                state_next = S_R2;
            end
            S_R2:
            begin
                // hold here until the output register is free
                mul_a = 33'(y_reg);
                mul_b = 33'(sv_reg[2]);
                if (!out_valid_reg || out_ready)
                begin
                    out_item_next.left_sample  = left_reg;
                    out_item_next.right_sample = sat12(acc_dif);
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // no second beat is taken while one is being worked
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while sequencer busy");

    // a result appears only from the last rotation step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_R2))
    else $error("result beat raised outside final step");

    // the oscillator phase moves only in its update step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_OSC) |=> $stable(osc_phase_reg))
    else $error("oscillator phase changed outside update step");

    // all four lookups are done before the point is formed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XY) |-> ($past(state_reg) == S_SC) && (sine_cnt_reg == 2'd0))
    else $error("point formed before all lookups finished");
`endif

endmodule

`default_nettype wire

// File: test/tb_yinyang_xy_oscillator.sv
// testbench for the yin-yang xy oscillator: scoreboard class, beat drivers and watchdog

module tb_yinyang_xy_oscillator;

    import yyxo_pkg::*;

    localparam int RANDOM_BEATS   = 600;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // expected sample pairs, worked out from the knob beats the block has taken
    class oscillator_scoreboard;
        int          sine_tab[TABLE_DEPTH];
        bit [31:0]   osc_phase;
        bit [31:0]   rot_phase;
        out_item_t   expected_q[$];
        int          errors;

        function new();
            int q;
            int v;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                q = i % 256;
                v = (q <= 128) ? series_amp(q) : series_amp(256 - q);
                sine_tab[i] = (i < 256) ? v : -v;
            end
            osc_phase = '0;
            rot_phase = '0;
            errors    = 0;
        endfunction

        function bit [127:0] wide_mul(bit [63:0] a, bit [63:0] b);
            return {64'd0, a} * {64'd0, b};
        endfunction

        // trunc(32000 * sin(k*pi/256)) by an odd power series in q62
        function int series_amp(int k);
            bit [63:0]  x;
            bit [63:0]  x2;
            bit [63:0]  term;
            bit [63:0]  sum;
            bit [127:0] p;
            if (k == 0)
                return 0;
            if (k >= 128)
                return 32000;
            p    = wide_mul(PI_Q62, 64'(k) << 56);
            x    = p[127:64];
            p    = wide_mul(x, x);
            x2   = p[125:62];
            term = x;
            sum  = x;
            for (int n = 1; n <= 12; n++)
            begin
                p    = wide_mul(term, x2);
                term = p[125:62] / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            p = wide_mul(sum, 64'd128000);
            return int'(p[127:64]);
        endfunction

        // interpolated lookup between neighbouring entries, index wraps
        function longint sine_lookup(bit [31:0] ph);
            int     idx;
            longint frac;
            longint a;
            longint b;
            idx  = int'(ph[31:23]);
            frac = longint'(ph[22:7]);
            a    = sine_tab[idx];
            b    = sine_tab[(idx + 1) % TABLE_DEPTH];
            return (b * frac + a * (65536 - frac)) >>> 20;
        endfunction

        function longint clamp12(longint v);
            if (v > 2047)
                return 2047;
            if (v < -2048)
                return -2048;
            return v;
        endfunction

        function void note_input(in_item_t beat);
            bit [31:0] osc2;
            bit [31:0] grow;
            bit [31:0] ph_all;
            bit [31:0] pb;
            bit [31:0] pe;
            bit [63:0] prod;
            longint    px;
            longint    py;
            longint    x;
            longint    y;
            longint    s;
            longint    c;
            out_item_t res;

            osc_phase = osc_phase + ((32'(beat.main_knob) * 32'(beat.main_knob)) << 3);
            rot_phase = rot_phase + ((32'(beat.y_knob) - 32'd2048) << 10);
            grow      = 32'(beat.x_knob) << 20;
            osc2      = osc_phase << 1;
            prod      = {32'd0, osc2} * {32'd0, grow};
            ph_all    = prod[63:32];

            if (ph_all[31:30] == 2'b11)
            begin
                // eye arc at quarter size, lifted by half
                pe = ph_all << 3;
                px = sine_lookup(pe) >>> 2;
                py = -(sine_lookup(pe + QUARTER_TURN) >>> 2) + 1024;
            end
            else
            begin
                prod = {32'd0, ph_all} * {32'd0, BODY_SCALE};
                pb   = prod[61:30];
                if (pb[31:30] == 2'b00)
                begin
                    px = sine_lookup(pb << 1) >>> 1;
                    py = -(sine_lookup((pb << 1) + QUARTER_TURN) >>> 1) + 1024;
                end
                else if (pb[31:30] == 2'b11)
                begin
                    px = sine_lookup(pb << 1) >>> 1;
                    py = (sine_lookup((pb << 1) + QUARTER_TURN) >>> 1) - 1024;
                end
                else
                begin
                    px = -sine_lookup(pb - QUARTER_TURN);
                    py = sine_lookup(pb);
                end
            end

            // second half cycle mirrors the figure
            if (osc_phase[31])
            begin
                x = -px;
                y = -py;
            end
            else
            begin
                x = px;
                y = py;
            end

            s = sine_lookup(rot_phase);
            c = sine_lookup(rot_phase + QUARTER_TURN);
            res.left_sample  = 12'(clamp12((x * s + y * c) >>> 12));
            res.right_sample = 12'(clamp12((-y * s + x * c) >>> 12));
            expected_q.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: sample pair with none expected: left %0d right %0d",
                         $time, got.left_sample, got.right_sample);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.left_sample !== want.left_sample)
            begin
                $display("%0t: left_sample expected %0d actual %0d",
                         $time, want.left_sample, got.left_sample);
                errors++;
            end
            if (got.right_sample !== want.right_sample)
            begin
                $display("%0t: right_sample expected %0d actual %0d",
                         $time, want.right_sample, got.right_sample);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    oscillator_scoreboard sb;

    // set by the stimulus, read by the drivers
    bit hold_output = 1'b0;
    bit no_idle     = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    yinyang_xy_oscillator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // knob reading, leaning towards the ends of travel and the centre
    function automatic logic [11:0] pick_knob();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'(2048 + $urandom_range(0, 8) - 4);
            default: return 12'($urandom);
        endcase
    endfunction

    // offer one beat; entered and left at a falling edge
    task automatic send_beat(input in_item_t beat);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_knobs(input logic [11:0] m, input logic [11:0] x, input logic [11:0] y);
        in_item_t beat;
        beat.main_knob = m;
        beat.x_knob    = x;
        beat.y_knob    = y;
        send_beat(beat);
    endtask

    // sender goes quiet until every expected pair has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // receiver: random back-pressure per beat, one long hold-off on request
    initial
    begin
        int gap;
        bit hold_done;
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_output && !hold_done)
            begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (no_idle)
                gap = 0;
            else
                gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // beats are noted and checked where they are taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_item);
            if (in_valid && in_ready)
                sb.note_input(in_item);
        end
    end

    // watchdog: too long without any beat moving ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_yinyang_xy_oscillator: FAIL");
        $finish;
    end

    initial
    begin
        in_item_t beat;
        sb       = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: knob extremes, centred and off-centre rotation
        send_knobs(12'd0,    12'd0,    12'd2048);
        send_knobs(12'd0,    12'd4095, 12'd0);
        send_knobs(12'd4095, 12'd0,    12'd4095);
        send_knobs(12'd4095, 12'd4095, 12'd4095);
        send_knobs(12'd4095, 12'd4095, 12'd0);
        send_knobs(12'd1,    12'd1,    12'd2047);
        send_knobs(12'd2048, 12'd2048, 12'd2049);
        send_knobs(12'd2730, 12'd1365, 12'd2048);
        // full knobs sweep the phase through eye, body arcs and the half-cycle flip
        for (int i = 0; i < 17; i++)
            send_knobs(12'd4095, 12'd4095, (i % 2 == 0) ? 12'd4095 : 12'd0);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == 150)
                hold_output = 1'b1;
            no_idle = (n >= 300 && n < 380);
            if (n == 450)
                wait_drained();
            beat.main_knob = pick_knob();
            beat.x_knob    = pick_knob();
            beat.y_knob    = pick_knob();
            send_beat(beat);
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_yinyang_xy_oscillator: PASS");
        else
            $display("tb_yinyang_xy_oscillator: FAIL");
        $finish;
    end

endmodule
